// ----- src/cee_pkg.sv -----
// ----------------------------------------------------------------------------
// cee_pkg
// Shared types and constants of the charset, line-ending and escape filter.
// ----------------------------------------------------------------------------
package cee_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CSI   = 8'h9b;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_WR1  = 2'd1;
    localparam logic [1:0] KIND_WR2  = 2'd2;

    localparam logic [1:0] EOL_PASS = 2'd0;
    localparam logic [1:0] EOL_CR   = 2'd1;
    localparam logic [1:0] EOL_LF   = 2'd2;
    localparam logic [1:0] EOL_BOTH = 2'd3;

    localparam logic [1:0] CFG_EOL_MODE  = 2'd0;
    localparam logic [1:0] CFG_STRIP_ESC = 2'd1;
    localparam logic [1:0] CFG_TAB1_ON   = 2'd2;
    localparam logic [1:0] CFG_TAB2_ON   = 2'd3;

    typedef struct packed {
        logic [1:0] eol_mode;
        logic       strip_esc;
        logic       tab1_on;
        logic       tab2_on;
    } t_cfg;

    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] xlat;
    } t_item;

    typedef enum logic {
        BK_RUN,
        BK_LF
    } t_back_state;

endpackage

// ----- src/charset_eol_escape_filter.sv -----
// A data item passes the lookup stages and the queue before reaching the output register.
// Throughput: one item per cycle if the output does not stall; CR LF delays the next item.
// The rate is set by the single output register; the table lookups are fully pipelined.
// Reset clears the configuration, the previous byte, the escape state and the queue.
// The translation tables are not cleared and must be loaded before they are used.
// ----------------------------------------------------------------------------
// charset_eol_escape_filter
// Text byte filter with table translation, line-ending conversion and
// optional removal of escape sequences.
// ----------------------------------------------------------------------------
module charset_eol_escape_filter #(
    parameter int QUEUE_DEPTH = cee_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_value,
    input  logic [7:0] i_entry_index,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cee_pkg::t_cfg  r_cfg;
    logic           w_push;
    cee_pkg::t_item w_push_item;
    logic           w_pop;
    logic           w_q_valid;
    cee_pkg::t_item w_head;
    logic [CW-1:0]  w_q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cee_pkg::CFG_EOL_MODE:  r_cfg.eol_mode  <= i_cfg_data;
                cee_pkg::CFG_STRIP_ESC: r_cfg.strip_esc <= i_cfg_data[0];
                cee_pkg::CFG_TAB1_ON:   r_cfg.tab1_on   <= i_cfg_data[0];
                cee_pkg::CFG_TAB2_ON:   r_cfg.tab2_on   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    cee_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_entry_index (i_entry_index),
        .i_cfg         (r_cfg),
        .i_q_count     (w_q_count),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    cee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_head),
        .o_count (w_q_count)
    );

    cee_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_item     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

// ----- src/cee_front.sv -----
// ----------------------------------------------------------------------------
// cee_front
// Accepts items, performs table writes and looks up both translation tables
// for data bytes in a two-stage pipeline that never stalls.
// ----------------------------------------------------------------------------
module cee_front #(
    parameter  int DEPTH = cee_pkg::QUEUE_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_value,
    input  logic [7:0]       i_entry_index,
    input  cee_pkg::t_cfg    i_cfg,
    input  logic [CW-1:0]    i_q_count,
    output logic             o_push,
    output cee_pkg::t_item   o_item
);

    logic [7:0] r_tab1 [256];
    logic [7:0] r_tab2 [256];

    logic       r_s1_v;
    logic [7:0] r_s1_c;
    logic [7:0] r_rd1;
    logic       r_s2_v;
    logic [7:0] r_s2_c;
    logic [7:0] r_s2_a;
    logic [7:0] r_rd2;

    logic       w_acc;
    logic [7:0] w_addr2;
    logic [CW:0] w_used;

    // Every item in the lookup pipeline has a queue slot reserved for it.
    assign w_used  = {1'b0, i_q_count} + (CW + 1)'(r_s1_v) + (CW + 1)'(r_s2_v);
    assign o_ready = w_used < (CW + 1)'(DEPTH);
    assign w_acc   = i_valid && o_ready;
    assign w_addr2 = i_cfg.tab1_on ? r_rd1 : r_s1_c;

    always_ff @(posedge i_clk) begin
        if (w_acc && i_kind == cee_pkg::KIND_WR1) begin
            r_tab1[i_entry_index] <= i_value;
        end
        r_rd1 <= r_tab1[i_value];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_kind == cee_pkg::KIND_WR2) begin
            r_tab2[i_entry_index] <= i_value;
        end
        r_rd2 <= r_tab2[w_addr2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_acc && i_kind == cee_pkg::KIND_DATA;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_c <= i_value;
        r_s2_c <= r_s1_c;
        r_s2_a <= w_addr2;
    end

    assign o_push      = r_s2_v;
    assign o_item.raw  = r_s2_c;
    assign o_item.xlat = i_cfg.tab2_on ? r_rd2 : r_s2_a;

endmodule

// ----- src/cee_queue.sv -----
// ----------------------------------------------------------------------------
// cee_queue
// Small first-in first-out queue between the lookup front and the back end.
// ----------------------------------------------------------------------------
module cee_queue #(
    parameter  int DEPTH = cee_pkg::QUEUE_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int PW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cee_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output cee_pkg::t_item  o_item,
    output logic [CW-1:0]   o_count
);

    cee_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] ptr);
        return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ----- src/cee_back.sv -----
// ----------------------------------------------------------------------------
// cee_back
// Applies line-ending conversion, escape removal and zero dropping in order,
// keeps the previous-byte and escape state, and drives the output register.
// ----------------------------------------------------------------------------
module cee_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cee_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  cee_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);

    cee_pkg::t_back_state r_state, n_state;
    logic [7:0] r_prev, n_prev;
    logic       r_esc, n_esc;
    logic       r_skip, n_skip;
    logic       r_o_v, n_o_v;
    logic [7:0] r_o_byte, n_o_byte;
    logic       r_o_last, n_o_last;

    logic       w_free;
    logic [1:0] w_cnt;
    logic [7:0] w_b0;
    logic [7:0] w_prev;
    logic       w_esc;
    logic       w_skip;

    // Outcome of the head item, given the current state.
    always_comb begin
        logic [7:0] c;
        logic       is_eol;
        logic       is_letter;
        logic       start_esc;
        c         = i_item.raw;
        is_eol    = c == cee_pkg::CH_CR || c == cee_pkg::CH_LF;
        is_letter = (c >= cee_pkg::CH_AT && c <= cee_pkg::CH_UZ) ||
                    (c >= cee_pkg::CH_LA && c <= cee_pkg::CH_LZ);
        start_esc = (c == cee_pkg::CH_ESC || c == cee_pkg::CH_CSI) && i_cfg.strip_esc;
        w_cnt  = 2'd0;
        w_b0   = c;
        w_prev = c;
        w_esc  = r_esc;
        w_skip = r_skip;
        if (is_eol) begin
            if (i_cfg.eol_mode == cee_pkg::EOL_PASS) begin
                w_cnt = 2'd1;
            end else if (c == cee_pkg::CH_CR || r_prev != cee_pkg::CH_CR) begin
                case (i_cfg.eol_mode)
                    cee_pkg::EOL_CR: begin
                        w_cnt = 2'd1;
                        w_b0  = cee_pkg::CH_CR;
                    end
                    cee_pkg::EOL_LF: begin
                        w_cnt = 2'd1;
                        w_b0  = cee_pkg::CH_LF;
                    end
                    default: begin
                        w_cnt = 2'd2;
                        w_b0  = cee_pkg::CH_CR;
                    end
                endcase
            end
        end else if (start_esc || r_esc) begin
            if (r_skip) begin
                w_esc  = 1'b0;
                w_skip = 1'b0;
            end else if (c == cee_pkg::CH_HASH) begin
                w_skip = 1'b1;
            end else if (is_letter) begin
                if (!(c == cee_pkg::CH_P &&
                      (r_prev == cee_pkg::CH_LBRK || r_prev == cee_pkg::CH_SEMI))) begin
                    w_esc = 1'b0;
                end
            end else if (c == cee_pkg::CH_SIX && r_prev == cee_pkg::CH_LPAR) begin
                w_esc = 1'b0;
            end else begin
                w_esc = 1'b1;
            end
        end else begin
            w_prev = i_item.xlat;
            w_b0   = i_item.xlat;
            w_cnt  = (i_item.xlat != 8'd0) ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        w_free   = !r_o_v || i_ready;
        n_state  = r_state;
        n_prev   = r_prev;
        n_esc    = r_esc;
        n_skip   = r_skip;
        n_o_v    = r_o_v && !i_ready;
        n_o_byte = r_o_byte;
        n_o_last = r_o_last;
        o_pop    = 1'b0;
        unique case (r_state)
            cee_pkg::BK_RUN: begin
                if (i_q_valid && w_free) begin
                    o_pop  = 1'b1;
                    n_prev = w_prev;
                    n_esc  = w_esc;
                    n_skip = w_skip;
                    if (w_cnt != 2'd0) begin
                        n_o_v    = 1'b1;
                        n_o_byte = w_b0;
                        n_o_last = w_cnt == 2'd1;
                    end
                    if (w_cnt == 2'd2) begin
                        n_state = cee_pkg::BK_LF;
                    end
                end
            end
            cee_pkg::BK_LF: begin
                if (w_free) begin
                    n_o_v    = 1'b1;
                    n_o_byte = cee_pkg::CH_LF;
                    n_o_last = 1'b1;
                    n_state  = cee_pkg::BK_RUN;
                end
            end
            default: begin
                n_state = cee_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cee_pkg::BK_RUN;
            r_prev  <= 8'd0;
            r_esc   <= 1'b0;
            r_skip  <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_esc   <= n_esc;
            r_skip  <= n_skip;
            r_o_v   <= n_o_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
    end

    assign o_valid    = r_o_v;
    assign o_out_byte = r_o_byte;
    assign o_last     = r_o_last;

endmodule

// ----- src/cee_checker.sv -----
// ----------------------------------------------------------------------------
// cee_checker
// Port-level checks of the filter output, attached to the top level.
// ----------------------------------------------------------------------------
module cee_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_ready,
    input logic       o_valid,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output changed");

    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_byte != 8'd0)
        else $error("zero byte delivered");

    a_first_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_out_byte == cee_pkg::CH_CR)
        else $error("non-final byte is not CR");

    a_lf_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=>
            o_valid && o_last && o_out_byte == cee_pkg::CH_LF)
        else $error("CR not followed by LF");

endmodule

bind charset_eol_escape_filter cee_checker u_cee_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_ready    (i_ready),
    .o_valid    (o_valid),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);
